>>> rtl/core/pdafm_pkg.sv
// Shared types and constants for the PDAF line pixel marker.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdafm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_W         = 3;

  localparam logic [COUNT_W-1:0] NEW_NONE    = 3'd0;
  localparam logic [COUNT_W-1:0] NEW_FULL    = 3'd5;
  localparam logic [COUNT_W-1:0] NEW_OVERLAP = 3'd2;

  // Result of the site test pipeline, handed to the run tracker.
  typedef struct packed {
    logic valid;
    logic cand;
    logic row_end;
  } site_res_t;

endpackage

`default_nettype wire

>>> rtl/core/pdafm_site_test.sv
// Three-stage site test: input register, sums and gap checks, products.
// Depends on pdafm_pkg (site_res_t).
`default_nettype none

module pdafm_site_test import pdafm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [SAMPLE_BITS-1:0] g_center,
  input  wire logic [SAMPLE_BITS-1:0] g_up_right,
  input  wire logic [SAMPLE_BITS-1:0] g_down_right,
  input  wire logic [SAMPLE_BITS-1:0] g_up_left,
  input  wire logic [SAMPLE_BITS-1:0] g_down_left,
  input  wire logic                   row_end,
  output site_res_t                   res
);

  localparam int HW = SAMPLE_BITS + 1;  // pair sum
  localparam int TW = SAMPLE_BITS + 2;  // total sum, 4g
  localparam int MW = SAMPLE_BITS + 6;  // scaled gap / diff
  localparam int PW = TW + HW;          // products

  // stage 0: input register
  logic                   s0_valid;
  logic                   s0_row_end;
  logic [SAMPLE_BITS-1:0] s0_g, s0_ur, s0_dr, s0_ul, s0_dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_row_end <= row_end;
      s0_g       <= g_center;
      s0_ur      <= g_up_right;
      s0_dr      <= g_down_right;
      s0_ul      <= g_up_left;
      s0_dl      <= g_down_left;
    end
  end

  // stage 1: peak test, pair sums, gap tests
  logic          peak;
  logic [HW-1:0] sum_dn, sum_up, hi, lo, gap;
  logic [MW-1:0] gap_x5, gap_x10;
  logic [TW-1:0] sum_all, g4;

  always_comb begin
    peak    = (s0_g > s0_ur) && (s0_g > s0_dr) && (s0_g > s0_ul) && (s0_g > s0_dl);
    sum_dn  = HW'(s0_dr) + HW'(s0_dl);
    sum_up  = HW'(s0_ur) + HW'(s0_ul);
    hi      = (sum_dn > sum_up) ? sum_dn : sum_up;
    lo      = (sum_dn > sum_up) ? sum_up : sum_dn;
    gap     = hi - lo;
    gap_x5  = (MW'(gap) << 2) + MW'(gap);
    gap_x10 = gap_x5 << 1;
    sum_all = TW'(sum_dn) + TW'(sum_up);
    g4      = {s0_g, 2'b00};
  end

  logic          s1_valid, s1_row_end, s1_pass, s1_small;
  logic [HW-1:0] s1_hi, s1_gap;
  logic [TW-1:0] s1_diff, s1_g4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_row_end <= s0_row_end;
      s1_pass    <= peak && (hi != '0) && (gap_x5 < MW'(hi));
      s1_small   <= gap_x10 < MW'(hi);
      s1_hi      <= hi;
      s1_gap     <= gap;
      s1_diff    <= g4 - sum_all;  // no wrap once the peak test passed
      s1_g4      <= g4;
    end
  end

  // stage 2: cross products and the coarse brightness test
  logic [MW-1:0] diff_x10;

  always_comb begin
    diff_x10 = (MW'(s1_diff) << 3) + (MW'(s1_diff) << 1);
  end

  logic          s2_valid, s2_row_end, s2_pass, s2_small, s2_ten_ok;
  logic [PW-1:0] s2_prod_bright, s2_prod_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row_end     <= s1_row_end;
      s2_pass        <= s1_pass;
      s2_small       <= s1_small;
      s2_ten_ok      <= diff_x10 > MW'(s1_g4);
      s2_prod_bright <= PW'(s1_diff) * PW'(s1_hi);
      s2_prod_gap    <= PW'(s1_g4) * PW'(s1_gap);
    end
  end

  always_comb begin
    res.valid   = s2_valid;
    res.row_end = s2_row_end;
    res.cand    = s2_pass && (s2_small ? (s2_prod_bright > s2_prod_gap) : s2_ten_ok);
  end

endmodule

`default_nettype wire

>>> rtl/core/pdaf_line_pixel_marker.sv
// Top level: site test pipeline, per-row run tracking and result register.
// Depends on pdafm_pkg and pdafm_site_test.
//
//   channel | signals                                 | transfer when
//   --------+-----------------------------------------+-----------------------
//   input   | in_valid in_ready g_* row_end           | in_valid & in_ready
//   output  | out_valid out_ready run_found new_count | out_valid & out_ready
//           | site_candidate                          |
//
// One item per cycle sustained while no result is held; out_valid for an item
// is set through the input register, sum stage, product stage and result
// register in turn.
// The whole pipeline holds while a result sits unaccepted; in_ready then drops.
// Synchronous active-high reset clears the stage valids and the row state.
`default_nettype none

module pdaf_line_pixel_marker import pdafm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [SAMPLE_BITS-1:0] g_center,
  input  wire logic [SAMPLE_BITS-1:0] g_up_right,
  input  wire logic [SAMPLE_BITS-1:0] g_down_right,
  input  wire logic [SAMPLE_BITS-1:0] g_up_left,
  input  wire logic [SAMPLE_BITS-1:0] g_down_left,
  input  wire logic                   row_end,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic                   run_found,
  output      logic [COUNT_W-1:0]     new_count,
  output      logic                   site_candidate
);

  logic      en;
  site_res_t site;

  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  pdafm_site_test #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_site (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .g_center     (g_center),
    .g_up_right   (g_up_right),
    .g_down_right (g_down_right),
    .g_up_left    (g_up_left),
    .g_down_left  (g_down_left),
    .row_end      (row_end),
    .res          (site)
  );

  // row state
  logic [1:0] cand_window;
  logic [1:0] sites_seen;
  logic       prev_run;
  logic       run;
  logic       step;

  assign step = en && site.valid;
  assign run  = site.cand && (sites_seen == 2'd2) && (cand_window == 2'b11);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_window <= 2'b00;
      sites_seen  <= 2'd0;
      prev_run    <= 1'b0;
    end else if (step) begin
      if (site.row_end) begin
        cand_window <= 2'b00;
        sites_seen  <= 2'd0;
        prev_run    <= 1'b0;
      end else begin
        cand_window <= {cand_window[0], site.cand};
        if (sites_seen != 2'd2) begin
          sites_seen <= sites_seen + 2'd1;
        end
        prev_run <= run;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= site.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      run_found      <= run;
      new_count      <= run ? (prev_run ? NEW_OVERLAP : NEW_FULL) : NEW_NONE;
      site_candidate <= site.cand;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pdafm_checker.sv
// Port-level checks for pdaf_line_pixel_marker, bound to the top level.
// Depends on pdafm_pkg for the count codes.
`default_nettype none

module pdafm_checker import pdafm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               run_found,
  input wire logic [COUNT_W-1:0] new_count,
  input wire logic               site_candidate
);

  // a run only ends on a candidate site
  a_run_needs_cand: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_found |-> site_candidate)
    else $error("run reported on a non-candidate site");

  a_count_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_found ? (new_count == NEW_FULL || new_count == NEW_OVERLAP)
                             : (new_count == NEW_NONE)))
    else $error("new_count does not match run_found");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_found) &&
                                $stable(new_count) && $stable(site_candidate))
    else $error("stalled result changed");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pdaf_line_pixel_marker pdafm_checker u_pdafm_checker (.*);

`default_nettype wire
